// ----- hw/rtl/tes_pkg.sv -----
package tes_pkg;

  localparam int unsigned TIME_W      = 32;
  localparam int unsigned HANDLE_W    = 8;
  localparam int unsigned KIND_W      = 3;
  localparam int unsigned HORIZON_W   = 31;
  localparam int unsigned WINDOW_W    = 16;
  localparam int unsigned CFG_IDX_W   = 1;
  localparam int unsigned CFG_DATA_W  = 31;
  localparam int unsigned QUEUE_DEPTH = 2;

  localparam logic [HORIZON_W-1:0] HORIZON_RESET = HORIZON_W'(200000);
  localparam logic [WINDOW_W-1:0]  WINDOW_RESET  = WINDOW_W'(2000);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_HORIZON = 1'b0,
    CFG_WINDOW  = 1'b1
  } cfg_idx_e;

  typedef enum logic {
    OP_ADD     = 1'b0,
    OP_ADVANCE = 1'b1
  } op_e;

  typedef enum logic [KIND_W-1:0] {
    KIND_FIRED      = 3'd0,
    KIND_DEADLINE   = 3'd1,
    KIND_ADDED      = 3'd2,
    KIND_NOT_FUTURE = 3'd3,
    KIND_FULL       = 3'd4
  } kind_e;

  // Classified request as it travels from the front to the engine
  typedef struct packed {
    op_e                 op;
    logic                not_future;
    logic [TIME_W-1:0]   now_time;
    logic [TIME_W-1:0]   due_time;
    logic [HANDLE_W-1:0] handle;
  } item_t;

endpackage

// ----- hw/rtl/tes_if.sv -----
interface tes_req_if import tes_pkg::*; ();
  logic                valid;
  logic                ready;
  logic                cmd;
  logic [TIME_W-1:0]   now_time;
  logic [TIME_W-1:0]   due_time;
  logic [HANDLE_W-1:0] handle;

  modport source (output valid, cmd, now_time, due_time, handle, input ready);
  modport sink   (input valid, cmd, now_time, due_time, handle, output ready);
endinterface

interface tes_rsp_if import tes_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [KIND_W-1:0]   kind;
  logic [HANDLE_W-1:0] handle_out;
  logic [TIME_W-1:0]   time_out;
  logic                last;

  modport source (output valid, kind, handle_out, time_out, last, input ready);
  modport sink   (input valid, kind, handle_out, time_out, last, output ready);
endinterface

// ----- hw/rtl/timed_event_scheduler.sv -----
// Flow: an accepted request passes the front stage register and then the queue to the engine;
//   a reject goes from idle straight to the final state, an add first moves later entries up
//   in the shift state (ending in the place state if all of them move), and an advance first
//   scans each occupied entry. The final result is registered, and a result stall holds the
//   engine. No new request is taken before the last one has its result; one table read port.
// Reset: table and queue empty, horizon 200000, late window 2000; entries undefined.
module timed_event_scheduler import tes_pkg::*; #(
  parameter int unsigned TABLE_DEPTH = 16,
  parameter int unsigned HANDLE_BITS = 8
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  tes_req_if.sink               req,
  tes_rsp_if.source             rsp,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);

  logic [HORIZON_W-1:0] horizon_q;
  logic [WINDOW_W-1:0]  window_q;

  logic    push_valid, push_ready;
  item_t   push_item;
  logic    pop_valid, pop_ready;
  item_t   pop_item;
  logic [CW-1:0] occ_count;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      horizon_q <= HORIZON_RESET;
      window_q  <= WINDOW_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_HORIZON: horizon_q <= cfg_data_i[HORIZON_W-1:0];
        CFG_WINDOW:  window_q  <= cfg_data_i[WINDOW_W-1:0];
        default: begin
          horizon_q <= horizon_q;
        end
      endcase
    end
  end

  tes_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req          (req),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_item_o  (push_item)
  );

  tes_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_item_i  (push_item),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_item_o   (pop_item)
  );

  tes_engine #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .HANDLE_BITS (HANDLE_BITS)
  ) u_engine (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .horizon_i    (horizon_q),
    .window_i     (window_q),
    .item_valid_i (pop_valid),
    .item_pop_o   (pop_ready),
    .item_i       (pop_item),
    .rsp          (rsp),
    .occ_count_o  (occ_count)
  );

  a_occ_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    occ_count <= CW'(TABLE_DEPTH))
    else $error("table occupancy beyond depth");

  a_occ_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (occ_count > $past(occ_count)) |-> (occ_count == $past(occ_count) + 1'b1))
    else $error("table grew by more than one entry");

  a_full_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp.valid && rsp.kind == KIND_FULL) |-> (occ_count == CW'(TABLE_DEPTH)))
    else $error("full rejection while table has room");

  a_deadline_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp.valid && rsp.kind == KIND_DEADLINE) |-> rsp.last)
    else $error("deadline result not marked last");

endmodule

// ----- hw/rtl/tes_front.sv -----
module tes_front import tes_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  tes_req_if.sink   req,
  output logic      push_valid_o,
  input  logic      push_ready_i,
  output item_t     push_item_o
);

  logic  stage_valid_q, stage_valid_d;
  item_t stage_q;
  item_t classified;
  logic  accept;

  assign req.ready = !stage_valid_q || push_ready_i;
  assign accept    = req.valid && req.ready;

  // An add whose due time is not strictly ahead of now is rejected downstream
  always_comb begin
    classified.op         = op_e'(req.cmd);
    classified.not_future = !(req.due_time > req.now_time);
    classified.now_time   = req.now_time;
    classified.due_time   = req.due_time;
    classified.handle     = req.handle;
  end

  always_comb begin
    stage_valid_d = stage_valid_q;
    if (accept) begin
      stage_valid_d = 1'b1;
    end else if (push_ready_i) begin
      stage_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_valid_q <= 1'b0;
    end else begin
      stage_valid_q <= stage_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      stage_q <= classified;
    end
  end

  assign push_valid_o = stage_valid_q;
  assign push_item_o  = stage_q;

endmodule

// ----- hw/rtl/tes_queue.sv -----
module tes_queue import tes_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_valid_i,
  output logic  push_ready_o,
  input  item_t push_item_i,
  output logic  pop_valid_o,
  input  logic  pop_ready_i,
  output item_t pop_item_o
);

  localparam int unsigned QAW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned QLW = $clog2(QUEUE_DEPTH + 1);

  item_t          slots [QUEUE_DEPTH];
  logic [QAW-1:0] wr_ptr_q, wr_ptr_d;
  logic [QAW-1:0] rd_ptr_q, rd_ptr_d;
  logic [QLW-1:0] level_q, level_d;
  logic           do_push, do_pop;

  assign push_ready_o = (level_q != QLW'(QUEUE_DEPTH));
  assign pop_valid_o  = (level_q != '0);
  assign do_push      = push_valid_i && push_ready_o;
  assign do_pop       = pop_valid_o && pop_ready_i;
  assign pop_item_o   = slots[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    level_d  = level_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == QAW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == QAW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      level_d = level_q + 1'b1;
    end else if (do_pop && !do_push) begin
      level_d = level_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      level_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      level_q  <= level_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slots[wr_ptr_q] <= push_item_i;
    end
  end

endmodule

// ----- hw/rtl/tes_engine.sv -----
module tes_engine import tes_pkg::*; #(
  parameter int unsigned TABLE_DEPTH = 16,
  parameter int unsigned HANDLE_BITS = 8,
  localparam int unsigned AW = $clog2(TABLE_DEPTH),
  localparam int unsigned CW = $clog2(TABLE_DEPTH + 1)
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic [HORIZON_W-1:0] horizon_i,
  input  logic [WINDOW_W-1:0]  window_i,
  input  logic                 item_valid_i,
  output logic                 item_pop_o,
  input  item_t                item_i,
  tes_rsp_if.source            rsp,
  output logic [CW-1:0]        occ_count_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SHIFT,
    ST_PLACE,
    ST_SCAN,
    ST_FINAL
  } state_e;

  state_e state_q, state_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [CW-1:0] idx_q, idx_d;
  logic [CW-1:0] wr_idx_q, wr_idx_d;
  logic [TIME_W-1:0] dl_q, dl_d;
  kind_e fkind_q, fkind_d;

  logic                out_valid_q, out_valid_d;
  kind_e               out_kind_q, out_kind_d;
  logic [HANDLE_W-1:0] out_hdl_q, out_hdl_d;
  logic [TIME_W-1:0]   out_time_q, out_time_d;
  logic                out_last_q, out_last_d;
  logic                out_load;

  // Event table
  logic [TIME_W-1:0]      due_mem [TABLE_DEPTH];
  logic [HANDLE_BITS-1:0] hdl_mem [TABLE_DEPTH];
  logic [TIME_W-1:0]      rd_due_q;
  logic [HANDLE_BITS-1:0] rd_hdl_q;
  logic                   mem_we, rd_en;
  logic [AW-1:0]          mem_wa, rd_a;
  logic [TIME_W-1:0]      mem_wdue;
  logic [HANDLE_BITS-1:0] mem_whdl;

  logic [CW-1:0] idx_m1, idx_m2, idx_p1, wr_idx_p1, cnt_p1;
  logic [HANDLE_BITS+HANDLE_W-1:0] hdl_in_ext;
  logic [HANDLE_BITS+HANDLE_W-1:0] hdl_out_ext;
  logic [HANDLE_BITS-1:0] new_hdl;
  logic [TIME_W-1:0] ahead, lag, dl_gap;
  logic future, fire, closer, can_emit;

  assign can_emit  = !out_valid_q || rsp.ready;
  assign idx_m1    = idx_q - 1'b1;
  assign idx_m2    = idx_q - CW'(2);
  assign idx_p1    = idx_q + 1'b1;
  assign wr_idx_p1 = wr_idx_q + 1'b1;
  assign cnt_p1    = cnt_q + 1'b1;

  assign hdl_in_ext  = {{HANDLE_BITS{1'b0}}, item_i.handle};
  assign new_hdl     = hdl_in_ext[HANDLE_BITS-1:0];
  assign hdl_out_ext = {{HANDLE_W{1'b0}}, rd_hdl_q};

  // Classify the entry in the read register against now
  assign ahead  = rd_due_q - item_i.now_time;
  assign lag    = item_i.now_time - rd_due_q;
  assign future = (ahead != '0) && !ahead[TIME_W-1];
  assign fire   = !future && (lag < {{(TIME_W-WINDOW_W){1'b0}}, window_i});
  assign dl_gap = dl_q - rd_due_q;
  assign closer = future && (dl_gap != '0) && !dl_gap[TIME_W-1];

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    idx_d       = idx_q;
    wr_idx_d    = wr_idx_q;
    dl_d        = dl_q;
    fkind_d     = fkind_q;
    out_valid_d = out_valid_q && !rsp.ready;
    out_kind_d  = out_kind_q;
    out_hdl_d   = out_hdl_q;
    out_time_d  = out_time_q;
    out_last_d  = out_last_q;
    out_load    = 1'b0;
    mem_we      = 1'b0;
    mem_wa      = idx_q[AW-1:0];
    mem_wdue    = item_i.due_time;
    mem_whdl    = new_hdl;
    rd_en       = 1'b0;
    rd_a        = idx_m1[AW-1:0];
    item_pop_o  = 1'b0;

    case (state_q)
      ST_IDLE: begin
        if (item_valid_i) begin
          if (item_i.op == OP_ADD) begin
            if (item_i.not_future) begin
              fkind_d = KIND_NOT_FUTURE;
              state_d = ST_FINAL;
            end else if (cnt_q == CW'(TABLE_DEPTH)) begin
              fkind_d = KIND_FULL;
              state_d = ST_FINAL;
            end else if (cnt_q == '0) begin
              idx_d   = '0;
              state_d = ST_PLACE;
            end else begin
              idx_d   = cnt_q;
              rd_en   = 1'b1;
              rd_a    = cnt_q[AW-1:0] - 1'b1;
              state_d = ST_SHIFT;
            end
          end else begin
            dl_d     = item_i.now_time + {1'b0, horizon_i};
            idx_d    = '0;
            wr_idx_d = '0;
            if (cnt_q == '0) begin
              fkind_d = KIND_DEADLINE;
              state_d = ST_FINAL;
            end else begin
              rd_en   = 1'b1;
              rd_a    = '0;
              state_d = ST_SCAN;
            end
          end
        end
      end

      ST_SHIFT: begin
        // Move the later entry up one slot, or drop the new one in behind it
        mem_we = 1'b1;
        mem_wa = idx_q[AW-1:0];
        if (rd_due_q > item_i.due_time) begin
          mem_wdue = rd_due_q;
          mem_whdl = rd_hdl_q;
          idx_d    = idx_m1;
          if (idx_m1 == '0) begin
            state_d = ST_PLACE;
          end else begin
            rd_en = 1'b1;
            rd_a  = idx_m2[AW-1:0];
          end
        end else begin
          cnt_d   = cnt_p1;
          fkind_d = KIND_ADDED;
          state_d = ST_FINAL;
        end
      end

      ST_PLACE: begin
        mem_we  = 1'b1;
        mem_wa  = idx_q[AW-1:0];
        cnt_d   = cnt_p1;
        fkind_d = KIND_ADDED;
        state_d = ST_FINAL;
      end

      ST_SCAN: begin
        if (!fire || can_emit) begin
          if (fire) begin
            out_load   = 1'b1;
            out_kind_d = KIND_FIRED;
            out_hdl_d  = hdl_out_ext[HANDLE_W-1:0];
            out_time_d = rd_due_q;
            out_last_d = 1'b0;
          end else begin
            // Compact survivors toward the front
            mem_we   = 1'b1;
            mem_wa   = wr_idx_q[AW-1:0];
            mem_wdue = rd_due_q;
            mem_whdl = rd_hdl_q;
            wr_idx_d = wr_idx_p1;
            if (closer) begin
              dl_d = rd_due_q;
            end
          end
          idx_d = idx_p1;
          if (idx_p1 < cnt_q) begin
            rd_en = 1'b1;
            rd_a  = idx_p1[AW-1:0];
          end else begin
            cnt_d   = fire ? wr_idx_q : wr_idx_p1;
            fkind_d = KIND_DEADLINE;
            state_d = ST_FINAL;
          end
        end
      end

      ST_FINAL: begin
        if (can_emit) begin
          out_load   = 1'b1;
          out_kind_d = fkind_q;
          out_hdl_d  = '0;
          out_time_d = (fkind_q == KIND_DEADLINE) ? dl_q : '0;
          out_last_d = 1'b1;
          item_pop_o = 1'b1;
          state_d    = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase

    if (out_load) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q      <= idx_d;
    wr_idx_q   <= wr_idx_d;
    dl_q       <= dl_d;
    fkind_q    <= fkind_d;
    out_kind_q <= out_kind_d;
    out_hdl_q  <= out_hdl_d;
    out_time_q <= out_time_d;
    out_last_q <= out_last_d;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      due_mem[mem_wa] <= mem_wdue;
      hdl_mem[mem_wa] <= mem_whdl;
    end
    if (rd_en) begin
      rd_due_q <= due_mem[rd_a];
      rd_hdl_q <= hdl_mem[rd_a];
    end
  end

  assign rsp.valid      = out_valid_q;
  assign rsp.kind       = out_kind_q;
  assign rsp.handle_out = out_hdl_q;
  assign rsp.time_out   = out_time_q;
  assign rsp.last       = out_last_q;
  assign occ_count_o    = cnt_q;

endmodule
